### rtl/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg: shared definitions for the running mean / variance core
// Default widths, operation codes and the command / status bundles that
// connect the controller with the datapath.
// ----------------------------------------------------------------------------
package rmvs_pkg;

   // default configuration
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int COUNT_WIDTH_DEF  = 32;

   // m2 and variance are unsigned 63-bit values
   localparam int M2_WIDTH = 63;

   // request operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;         // register sample, bump count, min/max, |delta|
      logic clear;           // zero every statistic
      logic mean_div_start;  // start |delta| / count
      logic mean_update;     // apply quotient to the mean
      logic mul_start;       // load the serial multiplier
      logic m2_update;       // accumulate scaled product into m2
      logic var_div_start;   // start m2 / (count - 1)
      logic publish;         // load the result register
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_busy;
      logic mul_busy;
      logic var_needed;      // count above one
   } dp_sts_type;

endpackage

### rtl/rmvs_divider.sv
// ----------------------------------------------------------------------------
// rmvs_divider: shared radix-2 restoring divider
// One quotient bit per cycle. The dividend is left-aligned by the caller and
// the number of steps selects how many of its top bits take part; the
// quotient ends up in the low bits of the quotient output.
// ----------------------------------------------------------------------------
module rmvs_divider
   import rmvs_pkg::*;
#(
   parameter int DIVIDEND_WIDTH = M2_WIDTH,
   parameter int DIVISOR_WIDTH  = COUNT_WIDTH_DEF,
   localparam int STEP_WIDTH    = $clog2(DIVIDEND_WIDTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [STEP_WIDTH-1:0]     steps,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      busy,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   logic [STEP_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] dq_ff, dq_in;
   logic [DIVISOR_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_WIDTH:0]    rem_sh;
   logic [DIVISOR_WIDTH+1:0]  diff;

   // trial subtraction of the shifted partial remainder
   assign rem_sh = {rem_ff, dq_ff[DIVIDEND_WIDTH-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dq_in  = dq_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = steps;
         rem_in = '0;
         dq_in  = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (diff[DIVISOR_WIDTH+1]) begin
            // borrow: keep the shifted remainder
            rem_in = rem_sh[DIVISOR_WIDTH-1:0];
            dq_in  = {dq_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff[DIVISOR_WIDTH-1:0];
            dq_in  = {dq_ff[DIVIDEND_WIDTH-2:0], 1'b1};
         end
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = dq_ff;

endmodule

### rtl/rmvs_datapath.sv
// ----------------------------------------------------------------------------
// rmvs_datapath: statistics registers and arithmetic
// Holds count, mean, m2, min and max, a bit-serial multiplier for the
// deviation product and the shared divider for the mean step and the
// variance. Every action is started by a command from the controller.
// ----------------------------------------------------------------------------
module rmvs_datapath
   import rmvs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_sts_type              sts,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   output logic [COUNT_WIDTH-1:0]  out_count,
   output logic [SAMPLE_WIDTH-1:0] out_mean,
   output logic [SAMPLE_WIDTH-1:0] out_min,
   output logic [SAMPLE_WIDTH-1:0] out_max,
   output logic [M2_WIDTH-1:0]     out_m2,
   output logic [M2_WIDTH-1:0]     out_var
);

   localparam int MAG_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * MAG_WIDTH;
   localparam int EXT_WIDTH  = (PROD_WIDTH > M2_WIDTH) ? PROD_WIDTH : M2_WIDTH + 1;
   localparam int MCNT_WIDTH = $clog2(MAG_WIDTH + 1);
   localparam int DSTEP_WIDTH = $clog2(M2_WIDTH + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [M2_WIDTH-1:0]    M2_MAX    = '1;

   // statistics
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [SAMPLE_WIDTH-1:0] mean_ff, mean_in;
   logic [SAMPLE_WIDTH-1:0] min_ff, min_in;
   logic [SAMPLE_WIDTH-1:0] max_ff, max_in;
   logic [M2_WIDTH-1:0]     m2_ff, m2_in;

   // per-sample working registers
   logic [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic [MAG_WIDTH-1:0]    dmag_ff, dmag_in;
   logic                    dneg_ff, dneg_in;

   // serial multiplier
   logic [PROD_WIDTH-1:0]   mcand_ff, mcand_in;
   logic [MAG_WIDTH-1:0]    mplier_ff, mplier_in;
   logic [PROD_WIDTH-1:0]   acc_ff, acc_in;
   logic [MCNT_WIDTH-1:0]   mcnt_ff, mcnt_in;

   // result register
   logic [COUNT_WIDTH-1:0]  rcount_ff;
   logic [SAMPLE_WIDTH-1:0] rmean_ff, rmin_ff, rmax_ff;
   logic [M2_WIDTH-1:0]     rm2_ff, rvar_ff;

   // intermediate values
   logic [MAG_WIDTH-1:0]    x_new_ext, x_cur_ext, mean_ext;
   logic [MAG_WIDTH-1:0]    delta, delta2, dmag2, mean_sum;
   logic [MAG_WIDTH-1:0]    quot_lo;
   logic [EXT_WIDTH-1:0]    prod_scaled;
   logic [M2_WIDTH-1:0]     inc;
   logic [M2_WIDTH:0]       m2_sum;
   logic                    div_start;
   logic [DSTEP_WIDTH-1:0]  div_steps;
   logic [M2_WIDTH-1:0]     div_dividend;
   logic [COUNT_WIDTH-1:0]  div_divisor;
   logic [M2_WIDTH-1:0]     div_quot;
   logic                    div_busy;

   // signed differences, one bit wider than a sample
   assign x_new_ext = {sample[SAMPLE_WIDTH-1], sample};
   assign x_cur_ext = {x_ff[SAMPLE_WIDTH-1], x_ff};
   assign mean_ext  = {mean_ff[SAMPLE_WIDTH-1], mean_ff};
   assign delta     = x_new_ext - mean_ext;
   assign delta2    = x_cur_ext - mean_ext;
   assign dmag2     = delta2[SAMPLE_WIDTH] ? (~delta2 + 1'b1) : delta2;

   // mean moves toward the sample by the truncated quotient
   assign quot_lo  = div_quot[MAG_WIDTH-1:0];
   assign mean_sum = dneg_ff ? (mean_ext - quot_lo) : (mean_ext + quot_lo);

   // product rescale and saturation to m2 range
   assign prod_scaled = EXT_WIDTH'(acc_ff) >> FRAC_BITS;
   assign inc    = (|prod_scaled[EXT_WIDTH-1:M2_WIDTH]) ? M2_MAX
                                                        : prod_scaled[M2_WIDTH-1:0];
   assign m2_sum = {1'b0, m2_ff} + {1'b0, inc};

   // divider operand selection
   assign div_start    = cmd.mean_div_start | cmd.var_div_start;
   assign div_steps    = cmd.var_div_start ? DSTEP_WIDTH'(M2_WIDTH)
                                           : DSTEP_WIDTH'(MAG_WIDTH);
   assign div_dividend = cmd.var_div_start ? m2_ff
                                           : {dmag_ff, {(M2_WIDTH-MAG_WIDTH){1'b0}}};
   assign div_divisor  = cmd.var_div_start ? (count_ff - 1'b1) : count_ff;

   rmvs_divider #(
      .DIVIDEND_WIDTH (M2_WIDTH),
      .DIVISOR_WIDTH  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // statistics next state
   always_comb begin
      count_in = count_ff;
      mean_in  = mean_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      m2_in    = m2_ff;
      x_in     = x_ff;
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      if (cmd.clear) begin
         count_in = '0;
         mean_in  = '0;
         min_in   = '0;
         max_in   = '0;
         m2_in    = '0;
      end else if (cmd.capture) begin
         x_in     = sample;
         count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         if ((count_ff == '0) || ($signed(sample) < $signed(min_ff))) begin
            min_in = sample;
         end
         if ((count_ff == '0) || ($signed(sample) > $signed(max_ff))) begin
            max_in = sample;
         end
         dneg_in = delta[SAMPLE_WIDTH];
         dmag_in = delta[SAMPLE_WIDTH] ? (~delta + 1'b1) : delta;
      end else if (cmd.mean_update) begin
         mean_in = mean_sum[SAMPLE_WIDTH-1:0];
      end else if (cmd.m2_update) begin
         m2_in = m2_sum[M2_WIDTH] ? M2_MAX : m2_sum[M2_WIDTH-1:0];
      end
   end

   // shift-and-add multiplier, one multiplier bit per cycle
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      mcnt_in   = mcnt_ff;
      if (cmd.mul_start) begin
         mcand_in  = PROD_WIDTH'(dmag_ff);
         mplier_in = dmag2;
         acc_in    = '0;
         mcnt_in   = MCNT_WIDTH'(MAG_WIDTH);
      end else if (mcnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MAG_WIDTH-1:1]};
         mcnt_in   = mcnt_ff - 1'b1;
      end
   end

   // statistics and control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         m2_ff    <= '0;
         mcnt_ff  <= '0;
      end else begin
         count_ff <= count_in;
         mean_ff  <= mean_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         m2_ff    <= m2_in;
         mcnt_ff  <= mcnt_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   // result register, loaded on publish
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rcount_ff <= count_ff;
         rmean_ff  <= mean_ff;
         rmin_ff   <= min_ff;
         rmax_ff   <= max_ff;
         rm2_ff    <= m2_ff;
         rvar_ff   <= sts.var_needed ? div_quot : '0;
      end
   end

   assign sts.div_busy   = div_busy;
   assign sts.mul_busy   = (mcnt_ff != '0);
   assign sts.var_needed = (count_ff > COUNT_WIDTH'(1));

   assign out_count = rcount_ff;
   assign out_mean  = rmean_ff;
   assign out_min   = rmin_ff;
   assign out_max   = rmax_ff;
   assign out_m2    = rm2_ff;
   assign out_var   = rvar_ff;

endmodule

### rtl/rmvs_ctrl.sv
// ----------------------------------------------------------------------------
// rmvs_ctrl: sequencer for one request at a time
// Walks the datapath through capture, mean division, deviation product,
// m2 update and, once the count exceeds one, variance division; a clear
// skips them. The result goes to the output register as soon as it is free.
// ----------------------------------------------------------------------------
module rmvs_ctrl
   import rmvs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_VAR_CHECK,
      ST_VAR_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MEAN_START;
               end
            end
         end
         ST_MEAN_START: begin
            cmd.mean_div_start = 1'b1;
            state_in           = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (!sts.div_busy) begin
               cmd.mean_update = 1'b1;
               state_in        = ST_MUL_START;
            end
         end
         ST_MUL_START: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (!sts.mul_busy) begin
               cmd.m2_update = 1'b1;
               state_in      = ST_VAR_CHECK;
            end
         end
         ST_VAR_CHECK: begin
            if (sts.var_needed) begin
               cmd.var_div_start = 1'b1;
               state_in          = ST_VAR_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_VAR_WAIT: begin
            if (!sts.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/running_mean_variance_stats_core.sv
// Requests: one at a time. An add request runs the mean division, the deviation
//   product, the m2 update and, once the count exceeds one, the variance division
//   before it responds; a clear responds without any of these steps.
// Pacing: set by the shared radix-2 divider (mean step and variance) and the
//   bit-serial multiplier; a new request waits until the previous one is published.
// Reset: synchronous, active high; all statistics return to zero, no response pending.
// ----------------------------------------------------------------------------
// running_mean_variance_stats_core: Welford running statistics
// Keeps count, mean, m2, min and max of a signed fixed-point sample stream
// and returns the updated statistics and sample variance per request.
// A finished response waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module running_mean_variance_stats_core
   import rmvs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
   localparam int REQ_DW      = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_FW      = COUNT_WIDTH + 3 * SAMPLE_WIDTH + 2 * M2_WIDTH,
   localparam int RSP_DW      = ((RSP_FW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // sample
   input  logic              req_tuser,   // operation
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata    // sample_count, running_mean, smallest,
                                          // largest, squared_deviation_sum,
                                          // sample_variance
);

   dp_cmd_type              cmd;
   dp_sts_type              sts;
   logic [COUNT_WIDTH-1:0]  out_count;
   logic [SAMPLE_WIDTH-1:0] out_mean, out_min, out_max;
   logic [M2_WIDTH-1:0]     out_m2, out_var;

   rmvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rmvs_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .sample    (req_tdata[SAMPLE_WIDTH-1:0]),
      .out_count (out_count),
      .out_mean  (out_mean),
      .out_min   (out_min),
      .out_max   (out_max),
      .out_m2    (out_m2),
      .out_var   (out_var)
   );

   // response packing, first field in the low bits
   assign rsp_tdata = RSP_DW'({out_var, out_m2, out_max, out_min, out_mean, out_count});

endmodule

### rtl/rmvs_checker.sv
// ----------------------------------------------------------------------------
// rmvs_checker: port-level checks for the running statistics core
// Watches the request and response channels and the consistency of the
// reported statistics; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module rmvs_checker
   import rmvs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
   localparam int REQ_DW      = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_FW      = COUNT_WIDTH + 3 * SAMPLE_WIDTH + 2 * M2_WIDTH,
   localparam int RSP_DW      = ((RSP_FW + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_DW-1:0] req_tdata,   // sample
   input logic              req_tuser,   // operation
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata    // sample_count, running_mean, smallest,
                                         // largest, squared_deviation_sum,
                                         // sample_variance
);

   localparam int MEAN_LO = COUNT_WIDTH;
   localparam int MIN_LO  = MEAN_LO + SAMPLE_WIDTH;
   localparam int MAX_LO  = MIN_LO + SAMPLE_WIDTH;
   localparam int M2_LO   = MAX_LO + SAMPLE_WIDTH;
   localparam int VAR_LO  = M2_LO + M2_WIDTH;

   logic [COUNT_WIDTH-1:0]  f_count;
   logic [SAMPLE_WIDTH-1:0] f_mean, f_min, f_max;
   logic [M2_WIDTH-1:0]     f_m2, f_var;
   logic                    req_fire;

   // response field extraction
   assign f_count  = rsp_tdata[COUNT_WIDTH-1:0];
   assign f_mean   = rsp_tdata[MEAN_LO +: SAMPLE_WIDTH];
   assign f_min    = rsp_tdata[MIN_LO +: SAMPLE_WIDTH];
   assign f_max    = rsp_tdata[MAX_LO +: SAMPLE_WIDTH];
   assign f_m2     = rsp_tdata[M2_LO +: M2_WIDTH];
   assign f_var    = rsp_tdata[VAR_LO +: M2_WIDTH];
   assign req_fire = req_tvalid & req_tready & (req_tdata[0] | ~req_tdata[0])
                     & (req_tuser | ~req_tuser);

   // one request in flight: no request taken right after another
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // no variance until two samples
   a_var_small_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (f_count == '0 || f_count == COUNT_WIDTH'(1)) |-> f_var == '0)
      else $error("variance nonzero with count at most one");

   // empty statistics report zero mean, min, max and m2
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && f_count == '0 |->
         f_mean == '0 && f_min == '0 && f_max == '0 && f_m2 == '0)
      else $error("statistics nonzero with count zero");

   // minimum never above maximum
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(f_min) <= $signed(f_max))
      else $error("smallest above largest");

endmodule

bind running_mean_variance_stats_core rmvs_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH),
   .FRAC_BITS    (FRAC_BITS),
   .COUNT_WIDTH  (COUNT_WIDTH)
) u_rmvs_checker (.*);
